### src/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Field widths, character codes and the job record that passes from the
// serial converter to the character sequencer.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int MAG_W   = 64;
    localparam int PADW_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 8'h61;
    localparam logic [DIGIT_W-1:0] DEC_BASE    = 4'd10;

    typedef struct packed {
        logic              negative;
        logic [PADW_W-1:0] pad_width;
        logic [CHAR_W-1:0] pad_char;
    } t_job;

    function automatic logic [CHAR_W-1:0] f_digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_BASE) begin
            return CHAR_ZERO + ext;
        end else begin
            return CHAR_A_LOWER + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_BASE};
        end
    endfunction

endpackage

### src/i2a_if.sv
// ----------------------------------------------------------------------------
// i2a_if: word channels of the integer to ASCII formatter
// The request channel carries one number to print, the character channel
// carries one formatted character with its end marker.
// ----------------------------------------------------------------------------
interface i2a_in_if;
    logic                           valid;
    logic                           ready;
    logic [i2a_pkg::MAG_W-1:0]      magnitude;
    logic                           negative;
    logic                           base_hex;
    logic [i2a_pkg::PADW_W-1:0]     pad_width;
    logic [i2a_pkg::CHAR_W-1:0]     pad_char;

    modport source (output valid, magnitude, negative, base_hex, pad_width, pad_char,
                    input ready);
    modport sink   (input valid, magnitude, negative, base_hex, pad_width, pad_char,
                    output ready);
endinterface

interface i2a_out_if;
    logic                           valid;
    logic                           ready;
    logic [i2a_pkg::CHAR_W-1:0]     char_out;
    logic                           last_char;

    modport source (output valid, char_out, last_char, input ready);
    modport sink   (input valid, char_out, last_char, output ready);
endinterface

### src/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: integer to ASCII formatter
// Prints an unsigned magnitude in decimal or lowercase hex with optional
// minus sign and front padding, one character word at a time.
// ----------------------------------------------------------------------------
// Usage:
// A request word on i_item carries the magnitude, the sign flag, the base,
// the pad width and the pad character. The block answers on o_char with the
// characters of the number: '-' when negative, pad characters up to the pad
// width, then the digits most significant first; last_char marks the final
// digit. Widths above MAX_PAD_WIDTH are treated as MAX_PAD_WIDTH.
// The converter takes one bit per cycle, so a request's first character is
// available only once its whole magnitude has been shifted in and the
// sequencer, when free, has taken the result and registered the first word.
// Characters then leave one per cycle while the receiver is ready.
// Conversion of the next request runs while the previous one is being sent.
// A stalled receiver holds the character word steady and the sequencer
// waits; a finished conversion waits in the converter, and i_item stays not
// ready until that result has moved on. Reset drops all words in flight.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top #(
    parameter int VALUE_BITS    = 64,
    parameter int MAX_PAD_WIDTH = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2a_in_if.sink     i_item,
    i2a_out_if.source  o_char
);

    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int NW         = $clog2(NUM_DIGITS + 1);
    localparam int DW         = i2a_pkg::DIGIT_W * NUM_DIGITS;

    logic            full;
    logic            take;
    i2a_pkg::t_job   job;
    logic [DW-1:0]   digits;
    logic [NW-1:0]   ndig;

    i2a_conv #(
        .VALUE_BITS    (VALUE_BITS),
        .MAX_PAD_WIDTH (MAX_PAD_WIDTH),
        .NUM_DIGITS    (NUM_DIGITS)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_take   (take),
        .o_full   (full),
        .o_job    (job),
        .o_digits (digits),
        .o_ndig   (ndig)
    );

    i2a_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_full   (full),
        .i_job    (job),
        .i_digits (digits),
        .i_ndig   (ndig),
        .o_take   (take),
        .o_char   (o_char)
    );

endmodule

### src/i2a_conv.sv
// ----------------------------------------------------------------------------
// i2a_conv: bit-serial radix converter
// Shifts the magnitude in one bit per cycle, most significant first, into a
// row of 4-bit digits; decimal mode applies the add-3 correction per digit.
// The count of significant digits is tracked as the digits fill up.
// ----------------------------------------------------------------------------
module i2a_conv #(
    parameter int VALUE_BITS    = 64,
    parameter int MAX_PAD_WIDTH = 48,
    parameter int NUM_DIGITS    = 20,
    localparam int CW = $clog2(VALUE_BITS),
    localparam int NW = $clog2(NUM_DIGITS + 1),
    localparam int IW = $clog2(NUM_DIGITS),
    localparam int DW = i2a_pkg::DIGIT_W * NUM_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    i2a_in_if.sink                i_item,
    input  logic                  i_take,
    output logic                  o_full,
    output i2a_pkg::t_job         o_job,
    output logic [DW-1:0]         o_digits,
    output logic [NW-1:0]         o_ndig
);

    logic                  r_busy;
    logic                  r_full;
    logic [CW-1:0]         r_bitcnt;
    logic [VALUE_BITS-1:0] r_shift;
    logic [DW-1:0]         r_digits;
    logic [NW-1:0]         r_ndig;
    logic                  r_hex;
    i2a_pkg::t_job         r_job;

    logic [DW-1:0]         n_adj;
    logic [DW-1:0]         n_digits;
    logic [NW-1:0]         n_ndig;
    logic [i2a_pkg::PADW_W-1:0] n_width;
    logic                  accept;

    assign i_item.ready = !r_busy && !r_full;
    assign accept       = i_item.valid && i_item.ready;

    assign n_width = (i_item.pad_width > i2a_pkg::PADW_W'(MAX_PAD_WIDTH)) ?
                     i2a_pkg::PADW_W'(MAX_PAD_WIDTH) : i_item.pad_width;

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (!r_hex && (r_digits[4*d +: 4] >= 4'd5)) begin
                n_adj[4*d +: 4] = r_digits[4*d +: 4] + 4'd3;
            end else begin
                n_adj[4*d +: 4] = r_digits[4*d +: 4];
            end
        end
        n_digits = {n_adj[DW-2:0], r_shift[VALUE_BITS-1]};
        n_ndig   = r_ndig;
        if ((r_ndig != NW'(NUM_DIGITS)) && (n_digits[4*r_ndig[IW-1:0] +: 4] != 4'd0)) begin
            n_ndig = r_ndig + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_full <= 1'b0;
        end else begin
            if (accept) begin
                r_busy   <= 1'b1;
                r_bitcnt <= CW'(VALUE_BITS - 1);
                r_shift  <= i_item.magnitude[VALUE_BITS-1:0];
                r_digits <= '0;
                r_ndig   <= NW'(1);
                r_hex    <= i_item.base_hex;
                r_job    <= '{negative:  i_item.negative,
                              pad_width: n_width,
                              pad_char:  i_item.pad_char};
            end else if (r_busy) begin
                r_shift  <= {r_shift[VALUE_BITS-2:0], 1'b0};
                r_digits <= n_digits;
                r_ndig   <= n_ndig;
                r_bitcnt <= r_bitcnt - CW'(1);
                if (r_bitcnt == '0) begin
                    r_busy <= 1'b0;
                    r_full <= 1'b1;
                end
            end
            if (r_full && i_take) begin
                r_full <= 1'b0;
            end
        end
    end

    assign o_full   = r_full;
    assign o_job    = r_job;
    assign o_digits = r_digits;
    assign o_ndig   = r_ndig;

endmodule

### src/i2a_emit.sv
// ----------------------------------------------------------------------------
// i2a_emit: character sequencer with output register
// Sends the sign, the padding and the digits of one converted number, one
// character per cycle while the receiver is ready, marking the final digit.
// ----------------------------------------------------------------------------
module i2a_emit #(
    parameter int NUM_DIGITS = 20,
    localparam int NW = $clog2(NUM_DIGITS + 1),
    localparam int IW = $clog2(NUM_DIGITS),
    localparam int DW = i2a_pkg::DIGIT_W * NUM_DIGITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_full,
    input  i2a_pkg::t_job         i_job,
    input  logic [DW-1:0]         i_digits,
    input  logic [NW-1:0]         i_ndig,
    output logic                  o_take,
    i2a_out_if.source             o_char
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SIGN  = 2'd1;
    localparam logic [1:0] ST_PAD   = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]                  r_state;
    logic [DW-1:0]               r_digits;
    logic [IW-1:0]               r_idx;
    logic [i2a_pkg::PADW_W-1:0]  r_padcnt;
    logic [i2a_pkg::CHAR_W-1:0]  r_pad;
    logic                        r_ovalid;
    logic [i2a_pkg::CHAR_W-1:0]  r_char;
    logic                        r_last;

    logic [i2a_pkg::PADW_W-1:0]  n_padcnt;
    logic [i2a_pkg::CHAR_W-1:0]  n_digit_char;
    logic                        load;
    logic                        adv;

    assign o_take = (r_state == ST_IDLE);
    assign load   = o_take && i_full;
    assign adv    = !r_ovalid || o_char.ready;

    assign n_padcnt = (i_job.pad_width > i2a_pkg::PADW_W'(i_ndig)) ?
                      (i_job.pad_width - i2a_pkg::PADW_W'(i_ndig)) : '0;
    assign n_digit_char = i2a_pkg::f_digit_char(r_digits[4*r_idx +: 4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_digits <= i_digits;
                r_idx    <= IW'(i_ndig - NW'(1));
                r_padcnt <= n_padcnt;
                r_pad    <= i_job.pad_char;
                if (i_job.negative) begin
                    r_state <= ST_SIGN;
                end else if (n_padcnt != '0) begin
                    r_state <= ST_PAD;
                end else begin
                    r_state <= ST_DIGIT;
                end
            end
            if (adv) begin
                r_ovalid <= (r_state != ST_IDLE);
                case (r_state)
                    ST_SIGN: begin
                        r_char  <= i2a_pkg::CHAR_MINUS;
                        r_last  <= 1'b0;
                        r_state <= (r_padcnt != '0) ? ST_PAD : ST_DIGIT;
                    end
                    ST_PAD: begin
                        r_char   <= r_pad;
                        r_last   <= 1'b0;
                        r_padcnt <= r_padcnt - i2a_pkg::PADW_W'(1);
                        if (r_padcnt == i2a_pkg::PADW_W'(1)) begin
                            r_state <= ST_DIGIT;
                        end
                    end
                    ST_DIGIT: begin
                        r_char <= n_digit_char;
                        r_last <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx - IW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_char.valid     = r_ovalid;
    assign o_char.char_out  = r_char;
    assign o_char.last_char = r_last;

endmodule

### src/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker: port-level checks of the integer to ASCII formatter
// Watches the request and character channels of the top level.
// ----------------------------------------------------------------------------
module i2a_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [i2a_pkg::CHAR_W-1:0]  i_out_char,
    input  logic                        i_out_last
);

    // Every conversion is serial, so the request channel closes after a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request channel ready right after an accepted word");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("character word valid right after reset");

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_char) && $stable(i_out_last)))
        else $error("stalled character word changed");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_char.valid),
    .i_out_ready (o_char.ready),
    .i_out_char  (o_char.char_out),
    .i_out_last  (o_char.last_char)
);
